// File: design/krg_pkg.sv
`default_nettype none

package krg_pkg;

  localparam logic [31:0] SeedMul    = 32'd1664525;
  localparam logic [31:0] SeedAdd    = 32'd1013904223;
  localparam logic [31:0] LcgMul     = 32'd69069;
  localparam logic [31:0] LcgAdd     = 32'd12345;
  localparam logic [31:0] MwcMul     = 32'd698769069;
  localparam int unsigned XsShiftA   = 13;
  localparam int unsigned XsShiftB   = 17;
  localparam int unsigned XsShiftC   = 5;
  localparam logic [31:0] LcgStart   = 32'd123456789;
  localparam logic [31:0] XsStart    = 32'd362436000;
  localparam logic [31:0] MwcStart   = 32'd521288629;
  localparam logic [31:0] CarryStart = 32'd7654321;

  localparam int unsigned NumWords = 4;
  localparam int unsigned WordSelW = $clog2(NumWords);

  typedef enum logic [WordSelW-1:0] {
    WORD_LCG   = 2'd0,
    WORD_XS    = 2'd1,
    WORD_MWC   = 2'd2,
    WORD_CARRY = 2'd3
  } word_sel_e;

  typedef struct packed {
    logic      load_req;
    logic      seed_load;
    logic      seed_step;
    word_sel_e seed_sel;
    logic      advance;
    logic      sum;
    logic      scale;
    logic      emit;
  } krg_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic scaled;
  } krg_status_t;

endpackage

`default_nettype wire

// File: design/krg_ctrl.sv
`default_nettype none

module krg_ctrl
  import krg_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         req_valid_i,
  output logic        req_ready_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  krg_status_t status_i,
  output krg_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SEED  = 6'b000010,
    ST_ADV   = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [WordSelW-1:0]  cnt_q, cnt_d;
  logic                 req_fire;
  logic                 cfg_fire;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign req_ready_o = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign req_fire    = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        priority if (cfg_fire) begin
          cmd_o.seed_load = 1'b1;
          cnt_d           = '0;
          state_d         = ST_SEED;
        end else if (req_fire) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_ADV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        cmd_o.seed_sel  = word_sel_e'(cnt_q);
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == WordSelW'(NumWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ADV: begin
        cmd_o.advance = 1'b1;
        state_d       = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = status_i.scaled ? ST_SCALE : ST_EMIT;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: design/krg_datapath.sv
`default_nettype none

module krg_datapath
  import krg_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  krg_cmd_t     cmd_i,
  output krg_status_t  status_o,
  input  wire          req_type_i,
  input  wire  [31:0]  bound_i,
  input  wire  [31:0]  seed_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [31:0]  value_o
);

  logic [31:0] lcg_q, lcg_d;
  logic [31:0] xs_q, xs_d;
  logic [31:0] mwc_q, mwc_d;
  logic [31:0] carry_q, carry_d;
  logic [31:0] seed_q;
  logic [31:0] seed_next;
  logic        type_q;
  logic [31:0] bound_q;
  logic [31:0] sum_q;
  logic [31:0] scaled_q;
  logic [31:0] out_q;
  logic        out_valid_q;

  logic [31:0] lcg_next;
  logic [31:0] xs_1, xs_2, xs_next;
  logic [63:0] mwc_t;
  logic [63:0] scale_prod;

  assign seed_next  = seed_q * SeedMul + SeedAdd;
  assign lcg_next   = lcg_q * LcgMul + LcgAdd;
  assign xs_1       = xs_q ^ (xs_q << XsShiftA);
  assign xs_2       = xs_1 ^ (xs_1 >> XsShiftB);
  assign xs_next    = xs_2 ^ (xs_2 << XsShiftC);
  assign mwc_t      = {32'd0, MwcMul} * {32'd0, mwc_q} + {32'd0, carry_q};
  assign scale_prod = {32'd0, sum_q} * {32'd0, bound_q};

  always_comb begin
    lcg_d   = lcg_q;
    xs_d    = xs_q;
    mwc_d   = mwc_q;
    carry_d = carry_q;
    if (cmd_i.seed_step) begin
      unique case (cmd_i.seed_sel)
        WORD_LCG:   lcg_d   = seed_next;
        WORD_XS:    xs_d    = seed_next;
        WORD_MWC:   mwc_d   = seed_next;
        WORD_CARRY: carry_d = seed_next;
        default:    lcg_d   = lcg_q;
      endcase
    end else if (cmd_i.advance) begin
      lcg_d   = lcg_next;
      xs_d    = xs_next;
      mwc_d   = mwc_t[31:0];
      carry_d = mwc_t[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q       <= LcgStart;
      xs_q        <= XsStart;
      mwc_q       <= MwcStart;
      carry_q     <= CarryStart;
      out_valid_q <= 1'b0;
    end else begin
      lcg_q   <= lcg_d;
      xs_q    <= xs_d;
      mwc_q   <= mwc_d;
      carry_q <= carry_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_load) begin
      seed_q <= seed_i;
    end else if (cmd_i.seed_step) begin
      seed_q <= seed_next;
    end
    if (cmd_i.load_req) begin
      type_q  <= req_type_i;
      bound_q <= bound_i;
    end
    if (cmd_i.sum) begin
      sum_q <= lcg_q + xs_q + mwc_q;
    end
    if (cmd_i.scale) begin
      scaled_q <= scale_prod[63:32];
    end
    if (cmd_i.emit) begin
      out_q <= type_q ? scaled_q : sum_q;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign status_o.scaled   = type_q;
  assign out_valid_o       = out_valid_q;
  assign value_o           = out_q;

endmodule

`default_nettype wire

// File: design/kiss_random_generator_unit.sv
// KISS random generator: lcg, xorshift and multiply-with-carry words summed.
// The sequencer steps each request through accept, advance, sum, scale multiply (scaled
// requests only) and output load, and takes no new request until its output is loaded;
// a held output stretches the output load step.
// A seed write keeps the unit busy while the words are reloaded, one seed multiply per word.
// Reset is asynchronous, active low, and loads the fixed start words.
`default_nettype none

module kiss_random_generator_unit
  import krg_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] bound
  input  wire         s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [31:0] cfg_data_i
);

  krg_cmd_t    cmd;
  krg_status_t status;

  krg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  krg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_type_i  (s_axis_tuser),
    .bound_i     (s_axis_tdata),
    .seed_i      (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .value_o     (m_axis_tdata)
  );

  // A request and a seed write are never taken in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid && s_axis_tready && cfg_valid_i && cfg_ready_o))
    else $error("request and seed write accepted together");

  // The unit is busy right after it takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !cfg_ready_o))
    else $error("unit ready in the cycle after a request");

  // A seed write blocks requests while the words are reloaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request taken during seed reload");

endmodule

`default_nettype wire
